// ===== rtl/core/sida_pkg.sv =====
// ============================================================================
// sida_pkg: shared types and constants for the decimal ASCII converter
// Holds field widths, character codes, the divide-by-ten reciprocal and the
// queue item passed from the front stage to the back stage.
// ============================================================================
package sida_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;

    // digit counter holds 0..MAX_DIGITS, digit index holds 0..MAX_DIGITS-1
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
    localparam logic [63:0] RECIP_TEN   = 64'h0000_0000_CCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// ============================================================================
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Emits '-' for negative values, then the decimal digits most significant
// first with leading zeros suppressed; the final character is flagged.
// ============================================================================
//
//  Channel   Handshake     Payload               Notes
//  -------   -----------   -------------------   ------------------------------
//  input     push / full   value[31:0] signed    one integer per transfer
//  result    pop / empty   character[7:0],       one ASCII character per
//                          last_char             transfer, last_char on final
//
//  Sequence: the back stage loads an item, peels one digit per cycle in the
//  divide-by-ten unit, then emits one character per cycle (sign plus digits)
//  through the output register while pop keeps that register free.
//  Reset: rst_n clears all control state; queues and output start empty.
//  Stalls: the front register and two-entry queue keep taking values while
//  the back stage works; full rises once both are occupied. A low pop holds
//  the output register and stalls the back stage at its next character.
//
module signed_int_to_decimal_ascii (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sida_pkg::VALUE_W-1:0] value,
    output logic                                empty,
    input  logic                                pop,
    output logic [sida_pkg::CHAR_W-1:0]         character,
    output logic                                last_char
);
    import sida_pkg::*;

    logic  front_valid;
    item_t front_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    item_t q_item;

    // classify sign and magnitude, hold until the queue has room
    sida_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (!q_full)
    );

    // decouple intake from digit work
    sida_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_item (front_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .q_empty (q_empty)
    );

    // extract digits, then emit the text one character per transfer
    sida_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last_char (last_char)
    );

    // every shown character is a minus sign or a decimal digit
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (character == CHAR_MINUS ||
                    (character >= CHAR_ZERO && character <= CHAR_ZERO + CHAR_W'(9))))
        else $error("result character outside sign and digit codes");

    // a minus sign is never the final character of a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && character == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last character");

    // the back stage never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // a minus sign is followed by a digit, not another minus sign
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && character == CHAR_MINUS) |=>
            (empty || character != CHAR_MINUS))
        else $error("two minus signs in a row");

endmodule

// ===== rtl/core/sida_front.sv =====
// ============================================================================
// sida_front: input stage
// Accepts a signed value, splits it into sign and unsigned magnitude, and
// holds the classified item until the queue takes it.
// ============================================================================
module sida_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sida_pkg::VALUE_W-1:0] value,
    output logic                                item_valid,
    output sida_pkg::item_t                     item,
    input  logic                                item_ready
);
    import sida_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign full   = valid_reg && !item_ready;
    assign accept = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (valid_reg && item_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next    = 1'b1;
            item_next.neg = value[VALUE_W-1];
            // unsigned negate: the most negative value maps to 2^31
            item_next.mag = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                             : VALUE_W'(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/sida_queue.sv =====
// ============================================================================
// sida_queue: short item queue
// Decouples the front stage from the back stage so each can stall alone.
// ============================================================================
module sida_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  sida_pkg::item_t wr_item,
    output logic            q_full,
    input  logic            rd_en,
    output sida_pkg::item_t rd_item,
    output logic            q_empty
);
    import sida_pkg::*;

    item_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = entries_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/core/sida_back.sv =====
// ============================================================================
// sida_back: digit extraction and character output
// Peels one decimal digit per cycle with a reciprocal multiply, then emits
// the sign and the digits, most significant first, through an output register.
// ============================================================================
module sida_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sida_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [sida_pkg::CHAR_W-1:0]   character,
    output logic                          last_char
);
    import sida_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    logic [CNT_W-1:0]     ndig_reg;
    logic [CNT_W-1:0]     ndig_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [CHAR_W-1:0]    out_char_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic [DIGIT_W-1:0]   digits_reg [MAX_DIGITS];

    logic [63:0]          prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [DIGIT_W-1:0]   rem;
    logic                 out_free;
    logic                 div_wr;

    // quotient and remainder of mag_reg / 10
    assign prod     = 64'(mag_reg) * RECIP_TEN;
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = DIGIT_W'(mag_reg - quot_x10);

    assign out_free = !out_valid_reg || pop;
    assign div_wr   = (state_reg == ST_DIVIDE);

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        ndig_next      = ndig_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    neg_next   = q_item.neg;
                    mag_next   = q_item.mag;
                    ndig_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                mag_next  = quot;
                ndig_next = ndig_reg + CNT_W'(1);
                if (quot == '0 || ndig_reg == CNT_W'(MAX_DIGITS - 1))
                begin
                    idx_next   = IDX_W'(ndig_reg);
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(digits_reg[idx_reg]);
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ndig_reg      <= '0;
            idx_reg       <= '0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            ndig_reg      <= ndig_next;
            idx_reg       <= idx_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_wr)
        begin
            digits_reg[IDX_W'(ndig_reg)] <= rem;
        end
    end

    assign empty     = !out_valid_reg;
    assign character = out_char_reg;
    assign last_char = out_last_reg;

endmodule
